// ===== src/mb3_pkg.sv =====
// Package for the 3x3 box mean filter: widths, register indexes, reset values,
// the reciprocal used for the divide by nine, and the stage flag struct.
// No dependencies.
`default_nettype none

package mb3_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam int PIX_W        = 8;
   localparam int COLSUM_W     = 10;
   localparam int SUM_W        = 12;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 13;

   localparam int MIN_DIM      = 3;
   localparam int HEIGHT_LIMIT = 4096;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // floor(s / 9) == (s * 7282) >> 16 for every s below 9 * 256
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

   typedef struct packed {
      logic row_ok;
      logic emit;
      logic row_end;
      logic frame_end;
   } pos_flags_type;

endpackage

`default_nettype wire

// ===== src/mb3_line_store.sv =====
// Line store memory: one entry per column holding the pixels of the two rows above.
// Synchronous write, registered read. Uses mb3_pkg.
`default_nettype none

module mb3_line_store #(
   parameter int MAX_WIDTH = mb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [COL_W-1:0]         rd_addr,
   output logic [2*mb3_pkg::PIX_W-1:0]   rd_data,
   input  wire logic                     wr_en,
   input  wire logic [COL_W-1:0]         wr_addr,
   input  wire logic [2*mb3_pkg::PIX_W-1:0] wr_data
);

   logic [2*mb3_pkg::PIX_W-1:0] mem [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/mb3_scan.sv =====
// Frame position tracker and configuration registers for the box mean filter.
// Produces the line store column and the border/end flags per input. Uses mb3_pkg.
`default_nettype none

module mb3_scan #(
   parameter int MAX_WIDTH = mb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [mb3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mb3_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            advance,
   output logic                                 restart,
   output logic [COL_W-1:0]                     col,
   output mb3_pkg::pos_flags_type               flags
);

   localparam int CMP_W = (COL_W + 1 > mb3_pkg::WIDTH_REG_W) ? COL_W + 1
                                                             : mb3_pkg::WIDTH_REG_W;
   localparam int HCMP_W = mb3_pkg::HEIGHT_REG_W;

   logic [mb3_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [mb3_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]                 col_ff, col_in;
   logic [mb3_pkg::ROW_W-1:0]        row_ff, row_in;

   logic [CMP_W-1:0]          w_ext, w_clamp;
   logic [HCMP_W-1:0]         h_ext, h_clamp;
   logic [COL_W-1:0]          col_last;
   logic [mb3_pkg::ROW_W-1:0] row_last;
   logic                      last_col, last_row;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            mb3_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[mb3_pkg::WIDTH_REG_W-1:0];
               restart  = 1'b1;
            end
            mb3_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      w_ext = CMP_W'(width_ff);
      if (w_ext < CMP_W'(mb3_pkg::MIN_DIM)) begin
         w_clamp = CMP_W'(mb3_pkg::MIN_DIM);
      end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
         w_clamp = CMP_W'(MAX_WIDTH);
      end else begin
         w_clamp = w_ext;
      end
      col_last = COL_W'(w_clamp - CMP_W'(1));

      h_ext = height_ff;
      if (h_ext < HCMP_W'(mb3_pkg::MIN_DIM)) begin
         h_clamp = HCMP_W'(mb3_pkg::MIN_DIM);
      end else if (h_ext > HCMP_W'(mb3_pkg::HEIGHT_LIMIT)) begin
         h_clamp = HCMP_W'(mb3_pkg::HEIGHT_LIMIT);
      end else begin
         h_clamp = h_ext;
      end
      row_last = mb3_pkg::ROW_W'(h_clamp - HCMP_W'(1));
   end

   assign last_col = (col_ff == col_last);
   assign last_row = (row_ff == row_last);

   always_comb begin
      col = col_ff;
      flags.row_ok    = (row_ff >= mb3_pkg::ROW_W'(2));
      flags.emit      = flags.row_ok && (col_ff >= COL_W'(2));
      flags.row_end   = last_col;
      flags.frame_end = last_col && last_row;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (advance) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + mb3_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mb3_pkg::WIDTH_RESET;
         height_ff <= mb3_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mb3_window.sv =====
// Window stage of the box mean filter: column sums, divide by nine, line store
// write-back and the result register with its handshake. Uses mb3_pkg.
`default_nettype none

module mb3_window #(
   parameter int MAX_WIDTH = mb3_pkg::DEFAULT_MAX_WIDTH,
   parameter int COL_W     = $clog2(MAX_WIDTH)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           restart,
   input  wire logic                           accept,
   input  wire logic [mb3_pkg::PIX_W-1:0]      pixel,
   input  wire logic [COL_W-1:0]               col,
   input  wire mb3_pkg::pos_flags_type         flags,
   input  wire logic [2*mb3_pkg::PIX_W-1:0]    rd_data,
   output logic                                wr_en,
   output logic [COL_W-1:0]                    wr_addr,
   output logic [2*mb3_pkg::PIX_W-1:0]         wr_data,
   output logic                                take_ok,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [mb3_pkg::PIX_W-1:0]           rsp_mean_out,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end
);

   localparam int PROD_W = mb3_pkg::SUM_W + mb3_pkg::RECIP_W;

   logic                            s1_valid_ff, s1_valid_in;
   logic [mb3_pkg::PIX_W-1:0]       s1_pixel_ff;
   logic [COL_W-1:0]                s1_col_ff;
   mb3_pkg::pos_flags_type          s1_flags_ff;

   logic [mb3_pkg::COLSUM_W-1:0]    left_ff, left_in, mid_ff, mid_in;
   logic                            out_valid_ff, out_valid_in;
   logic [mb3_pkg::PIX_W-1:0]       mean_ff;
   logic                            row_end_ff, frame_end_ff;

   logic                            s1_adv;
   logic [mb3_pkg::PIX_W-1:0]       older_px, newer_px;
   logic [mb3_pkg::COLSUM_W-1:0]    col3, cur;
   logic [mb3_pkg::SUM_W-1:0]       box_sum;
   logic [PROD_W-1:0]               prod;
   logic [mb3_pkg::PIX_W-1:0]       quot;

   assign s1_adv  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign take_ok = !s1_valid_ff || s1_adv;

   assign older_px = rd_data[2*mb3_pkg::PIX_W-1:mb3_pkg::PIX_W];
   assign newer_px = rd_data[mb3_pkg::PIX_W-1:0];

   always_comb begin
      col3 = mb3_pkg::COLSUM_W'(older_px) + mb3_pkg::COLSUM_W'(newer_px)
           + mb3_pkg::COLSUM_W'(s1_pixel_ff);
      cur  = s1_flags_ff.row_ok ? col3 : '0;
      box_sum = mb3_pkg::SUM_W'(left_ff) + mb3_pkg::SUM_W'(mid_ff)
              + mb3_pkg::SUM_W'(cur);
      prod = PROD_W'(box_sum) * PROD_W'(mb3_pkg::RECIP_9);
      quot = prod[mb3_pkg::RECIP_SHIFT +: mb3_pkg::PIX_W];
   end

   // shift the older row out, the incoming pixel becomes the newer row
   assign wr_en   = s1_adv;
   assign wr_addr = s1_col_ff;
   assign wr_data = {newer_px, s1_pixel_ff};

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      left_in = left_ff;
      mid_in  = mid_ff;
      if (restart) begin
         left_in = '0;
         mid_in  = '0;
      end else if (s1_adv) begin
         left_in = mid_ff;
         mid_in  = cur;
      end
      if (s1_adv) begin
         out_valid_in = s1_flags_ff.emit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         mid_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         mid_ff       <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= pixel;
         s1_col_ff   <= col;
         s1_flags_ff <= flags;
      end
      if (s1_adv && s1_flags_ff.emit) begin
         mean_ff      <= quot;
         row_end_ff   <= s1_flags_ff.row_end;
         frame_end_ff <= s1_flags_ff.frame_end;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_mean_out  = mean_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

`default_nettype wire

// ===== src/box_mean_3x3_filter.sv =====
// Top level of the 3x3 box mean filter: line store, position tracker, window stage.
// Depends on mb3_pkg, mb3_line_store, mb3_scan and mb3_window.
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/ready    req_pixel_in
//   rsp_        out        rsp_valid/ready    rsp_mean_out, rsp_row_end, rsp_frame_end
//   csr_        in         csr_write_en       csr_index, csr_wdata
//
// One pixel per clock sustained while results are taken; results are registered.
// The line store takes one read at acceptance and one write as stage 1 advances;
// a column is revisited only after the full row, so no forwarding is needed.
// Reset and any register write restart the frame at row 0, column 0.
// A stalled result holds the window stage; the input takes a pixel while one is free.
`default_nettype none

module box_mean_3x3_filter #(
   parameter int MAX_WIDTH = mb3_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [mb3_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [mb3_pkg::PIX_W-1:0]            rsp_mean_out,
   output logic                                 rsp_row_end,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_write_en,
   input  wire logic [mb3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mb3_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                             accept;
   logic                             restart;
   logic [COL_W-1:0]                 col;
   mb3_pkg::pos_flags_type           flags;
   logic [2*mb3_pkg::PIX_W-1:0]      rd_data;
   logic                             wr_en;
   logic [COL_W-1:0]                 wr_addr;
   logic [2*mb3_pkg::PIX_W-1:0]      wr_data;
   logic                             take_ok;

   assign req_ready = take_ok;
   assign accept    = req_valid && take_ok;

   mb3_scan #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .advance      (accept),
      .restart      (restart),
      .col          (col),
      .flags        (flags)
   );

   mb3_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   mb3_window #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_W     (COL_W)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .accept        (accept),
      .pixel         (req_pixel_in),
      .col           (col),
      .flags         (flags),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .take_ok       (take_ok),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_mean_out  (rsp_mean_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

// ===== src/mb3_checker.sv =====
// Port-level checks for the box mean filter, bound to the top level.
// Depends on box_mean_3x3_filter and mb3_pkg.
`default_nettype none

module mb3_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [mb3_pkg::PIX_W-1:0]  rsp_mean_out,
   input wire logic                       rsp_row_end,
   input wire logic                       rsp_frame_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_out)
         && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("result transaction changed while stalled");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without an input transaction two cycles before");

endmodule

bind box_mean_3x3_filter mb3_checker u_mb3_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_mean_out  (rsp_mean_out),
   .rsp_row_end   (rsp_row_end),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire
